### design/gn2d_pkg.sv
package gn2d_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int IDX_W          = $clog2(TABLE_SIZE);
    localparam int COORD_W        = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic {
        MODE_EVAL = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

    // gradient hash selection: codes A and B pick x as the second term, the others are bounds
    localparam logic [3:0] GRAD_V_X_A = 4'd12;
    localparam logic [3:0] GRAD_V_X_B = 4'd14;
    localparam logic [3:0] GRAD_U_Y_MIN = 4'd8;
    localparam logic [3:0] GRAD_V_Y_LIM = 4'd4;

endpackage

### design/gn2d_if.sv
interface gn2d_in_if;
    import gn2d_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [COORD_W-1:0]  x_coord;
    logic signed [COORD_W-1:0]  y_coord;
    logic [IDX_W-1:0]           table_index;
    logic [IDX_W-1:0]           table_value;

    modport source (output valid, mode, x_coord, y_coord, table_index, table_value,
                    input ready);
    modport sink   (input valid, mode, x_coord, y_coord, table_index, table_value,
                    output ready);
endinterface

interface gn2d_out_if #(parameter int OUT_W = 18);
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

### design/gradient_noise_2d_top.sv
// 2D improved gradient noise, signed Q1.F result from Q15.F style coordinates.
// Six-stage pipeline: one beat accepted per cycle while no stall reaches the
// input. Load beats (mode 1) travel down the same pipe and update the private
// copies of the permutation table held by stages 1 to 3 as they pass, so
// loads and evaluations keep their order. Load beats produce no output beat.
// A stall reaches the input in the same cycle through a combinational advance
// chain; empty stages absorb it.
module gradient_noise_2d_top #(
    parameter int FRAC_BITS = gn2d_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gn2d_in_if.sink     i_in,
    gn2d_out_if.source  o_out
);
    import gn2d_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int D  = F + 1;      // corner offsets
    localparam int G  = F + 3;      // gradient values
    localparam int PW = F + 5;      // poly / fade
    localparam int LW = F + 6;      // lerp results
    localparam int OW = F + 2;

    function automatic logic signed [G-1:0] grad(
        input logic [3:0] h,
        input logic signed [D-1:0] dx,
        input logic signed [D-1:0] dy
    );
        logic signed [G-1:0] u;
        logic signed [G-1:0] v;
        u = (h < GRAD_U_Y_MIN) ? G'(dx) : G'(dy);
        if (h < GRAD_V_Y_LIM)
            v = G'(dy);
        else if (h == GRAD_V_X_A || h == GRAD_V_X_B)
            v = G'(dx);
        else
            v = '0;
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    // stage valids and advance chain
    logic [6:1] r_v;
    logic [6:1] adv;
    logic r_mode1, r_mode2, r_mode3, r_mode4, r_mode5, r_mode6;

    assign adv[6] = !r_v[6] || r_mode6 || o_out.ready;
    assign adv[5] = !r_v[5] || adv[6];
    assign adv[4] = !r_v[4] || adv[5];
    assign adv[3] = !r_v[3] || adv[4];
    assign adv[2] = !r_v[2] || adv[3];
    assign adv[1] = !r_v[1] || adv[2];
    assign i_in.ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) r_v[1] <= i_in.valid;
            if (adv[2]) r_v[2] <= r_v[1];
            if (adv[3]) r_v[3] <= r_v[2];
            if (adv[4]) r_v[4] <= r_v[3];
            if (adv[5]) r_v[5] <= r_v[4];
            if (adv[6]) r_v[6] <= r_v[5];
        end
    end

    // table copies
    logic [IDX_W-1:0] r_m1  [TABLE_SIZE];
    logic [IDX_W-1:0] r_m2a [TABLE_SIZE];
    logic [IDX_W-1:0] r_m2b [TABLE_SIZE];
    logic [IDX_W-1:0] r_m3a [TABLE_SIZE];
    logic [IDX_W-1:0] r_m3b [TABLE_SIZE];

    // ---------------- stage 1
    logic [F-1:0]            xf0, yf0;
    logic [IDX_W-1:0]        xi0, yi0;
    logic signed [PW-1:0]    n_polyx, n_polyy;
    logic [F-1:0]            n_t2x, n_t2y;
    logic [IDX_W-1:0]        r_idx1, r_val1, r_yi1, r_pa1, r_pb1;
    logic [F-1:0]            r_xf1, r_yf1, r_t2x1, r_t2y1;
    logic signed [PW-1:0]    r_polyx1, r_polyy1;

    function automatic logic signed [PW-1:0] poly_of(input logic [F-1:0] t);
        logic signed [PW-1:0]     m;
        logic signed [F+PW:0]     p;
        m = PW'(6) * $signed({{(PW-F){1'b0}}, t}) - (PW'(15) <<< F);
        p = $signed({1'b0, t}) * m;
        return PW'(p >>> F) + (PW'(10) <<< F);
    endfunction

    assign xf0 = i_in.x_coord[F-1:0];
    assign yf0 = i_in.y_coord[F-1:0];
    assign xi0 = i_in.x_coord[F+IDX_W-1:F];
    assign yi0 = i_in.y_coord[F+IDX_W-1:F];

    always_comb begin
        n_polyx = poly_of(xf0);
        n_polyy = poly_of(yf0);
        n_t2x   = F'(({{F{1'b0}}, xf0} * {{F{1'b0}}, xf0}) >> F);
        n_t2y   = F'(({{F{1'b0}}, yf0} * {{F{1'b0}}, yf0}) >> F);
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && adv[1] && i_in.mode == MODE_LOAD)
            r_m1[i_in.table_index] <= i_in.table_value;
        if (adv[1]) begin
            r_mode1  <= i_in.mode;
            r_idx1   <= i_in.table_index;
            r_val1   <= i_in.table_value;
            r_yi1    <= yi0;
            r_xf1    <= xf0;
            r_yf1    <= yf0;
            r_polyx1 <= n_polyx;
            r_polyy1 <= n_polyy;
            r_t2x1   <= n_t2x;
            r_t2y1   <= n_t2y;
            r_pa1    <= r_m1[xi0];
            r_pb1    <= r_m1[xi0 + IDX_W'(1)];
        end
    end

    // ---------------- stage 2
    logic [IDX_W-1:0]     a1, b1;
    logic [IDX_W-1:0]     r_idx2, r_val2, r_aa2, r_ab2, r_ba2, r_bb2;
    logic [F-1:0]         r_xf2, r_yf2, r_cx2, r_cy2;
    logic signed [PW-1:0] r_polyx2, r_polyy2;

    assign a1 = r_pa1 + r_yi1;
    assign b1 = r_pb1 + r_yi1;

    always_ff @(posedge i_clk) begin
        if (r_v[1] && adv[2] && r_mode1 == MODE_LOAD) begin
            r_m2a[r_idx1] <= r_val1;
            r_m2b[r_idx1] <= r_val1;
        end
        if (adv[2]) begin
            r_mode2  <= r_mode1;
            r_idx2   <= r_idx1;
            r_val2   <= r_val1;
            r_xf2    <= r_xf1;
            r_yf2    <= r_yf1;
            r_polyx2 <= r_polyx1;
            r_polyy2 <= r_polyy1;
            r_cx2    <= F'(({{F{1'b0}}, r_t2x1} * {{F{1'b0}}, r_xf1}) >> F);
            r_cy2    <= F'(({{F{1'b0}}, r_t2y1} * {{F{1'b0}}, r_yf1}) >> F);
            r_aa2    <= r_m2a[a1];
            r_ab2    <= r_m2a[a1 + IDX_W'(1)];
            r_ba2    <= r_m2b[b1];
            r_bb2    <= r_m2b[b1 + IDX_W'(1)];
        end
    end

    // ---------------- stage 3
    logic [IDX_W-1:0]     r_haa3, r_hab3, r_hba3, r_hbb3;
    logic [F-1:0]         r_xf3, r_yf3;
    logic signed [PW-1:0] r_fu3, r_fv3;
    logic signed [F+PW:0] fprod_x, fprod_y;

    assign fprod_x = $signed({1'b0, r_cx2}) * r_polyx2;
    assign fprod_y = $signed({1'b0, r_cy2}) * r_polyy2;

    always_ff @(posedge i_clk) begin
        if (r_v[2] && adv[3] && r_mode2 == MODE_LOAD) begin
            r_m3a[r_idx2] <= r_val2;
            r_m3b[r_idx2] <= r_val2;
        end
        if (adv[3]) begin
            r_mode3 <= r_mode2;
            r_xf3   <= r_xf2;
            r_yf3   <= r_yf2;
            r_fu3   <= PW'(fprod_x >>> F);
            r_fv3   <= PW'(fprod_y >>> F);
            r_haa3  <= r_m3a[r_aa2];
            r_hab3  <= r_m3a[r_ab2];
            r_hba3  <= r_m3b[r_ba2];
            r_hbb3  <= r_m3b[r_bb2];
        end
    end

    // ---------------- stage 4: corner gradients
    logic signed [D-1:0]  dx0, dy0, dx1, dy1;
    logic signed [G-1:0]  r_gaa4, r_gba4, r_gab4, r_gbb4;
    logic signed [PW-1:0] r_fu4, r_fv4;

    assign dx0 = $signed({1'b0, r_xf3});
    assign dy0 = $signed({1'b0, r_yf3});
    assign dx1 = dx0 - (D'(1) <<< F);
    assign dy1 = dy0 - (D'(1) <<< F);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_mode4 <= r_mode3;
            r_fu4   <= r_fu3;
            r_fv4   <= r_fv3;
            r_gaa4  <= grad(r_haa3[3:0], dx0, dy0);
            r_gba4  <= grad(r_hba3[3:0], dx1, dy0);
            r_gab4  <= grad(r_hab3[3:0], dx0, dy1);
            r_gbb4  <= grad(r_hbb3[3:0], dx1, dy1);
        end
    end

    // ---------------- stage 5: lerp along x
    logic signed [G:0]         dtop, dbot;
    logic signed [PW+G:0]      ptop, pbot;
    logic signed [LW-1:0]      r_top5, r_bot5;
    logic signed [PW-1:0]      r_fv5;

    assign dtop = $signed({r_gba4[G-1], r_gba4}) - $signed({r_gaa4[G-1], r_gaa4});
    assign dbot = $signed({r_gbb4[G-1], r_gbb4}) - $signed({r_gab4[G-1], r_gab4});
    assign ptop = r_fu4 * dtop;
    assign pbot = r_fu4 * dbot;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_mode5 <= r_mode4;
            r_fv5   <= r_fv4;
            r_top5  <= LW'(r_gaa4) + LW'(ptop >>> F);
            r_bot5  <= LW'(r_gab4) + LW'(pbot >>> F);
        end
    end

    // ---------------- stage 6: lerp along y, saturate
    logic signed [LW:0]        dres;
    logic signed [PW+LW:0]     pres;
    logic signed [LW+1:0]      res;
    logic signed [OW-1:0]      n_out;
    logic signed [OW-1:0]      r_out6;
    localparam logic signed [LW+1:0] LIM_HI = (LW+2)'((64'sd1 <<< (OW-1)) - 1);
    localparam logic signed [LW+1:0] LIM_LO = -(LW+2)'(64'sd1 <<< (OW-1));

    assign dres = $signed({r_bot5[LW-1], r_bot5}) - $signed({r_top5[LW-1], r_top5});
    assign pres = r_fv5 * dres;
    assign res  = (LW+2)'(r_top5) + (LW+2)'(pres >>> F);

    always_comb begin
        if (res > LIM_HI)
            n_out = LIM_HI[OW-1:0];
        else if (res < LIM_LO)
            n_out = LIM_LO[OW-1:0];
        else
            n_out = res[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_mode6 <= r_mode5;
            r_out6  <= n_out;
        end
    end

    assign o_out.valid       = r_v[6] && r_mode6 == MODE_EVAL;
    assign o_out.noise_value = r_out6;

endmodule

### design/gn2d_chk.sv
module gn2d_chk #(
    parameter int OUT_W = 18
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [OUT_W-1:0] out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output beat changed while stalled");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_ready_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while output drains");
endmodule

bind gradient_noise_2d_top gn2d_chk #(.OUT_W(FRAC_BITS + 2)) u_gn2d_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.noise_value)
);

### tb/sv/tb.sv
module tb;
    import gn2d_pkg::*;

    localparam int F        = FRAC_BITS_DEF;
    localparam int OUT_W    = F + 2;
    localparam int WD_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;

    gn2d_in_if                  in_bus();
    gn2d_out_if #(.OUT_W(OUT_W)) out_bus();

    gradient_noise_2d_top #(.FRAC_BITS(F)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    logic [7:0]              perm_copy [TABLE_SIZE];
    logic signed [OUT_W-1:0] noise_expected [$];
    int                      error_count;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    int                      idle_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---- predictor ----
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> F;   // arithmetic shift floors
    endfunction

    function automatic longint fade(longint t);
        longint poly, cube;
        poly = fx_mul(t, t * 6 - 15 * (longint'(1) << F)) + 10 * (longint'(1) << F);
        cube = fx_mul(fx_mul(t, t), t);
        return fx_mul(cube, poly);
    endfunction

    function automatic longint grad_dot(logic [7:0] hash, longint dx, longint dy);
        logic [3:0] h;
        longint     u, v;
        h = hash[3:0];
        u = (h < GRAD_U_Y_MIN) ? dx : dy;
        if (h < GRAD_V_Y_LIM)
            v = dy;
        else if (h == GRAD_V_X_A || h == GRAD_V_X_B)
            v = dx;
        else
            v = 0;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic longint lerp(longint a, longint b, longint t);
        return a + fx_mul(t, b - a);
    endfunction

    function automatic logic signed [OUT_W-1:0] noise_at(logic [31:0] x, logic [31:0] y);
        logic [7:0] xi, yi, a, b, aa, ab, ba, bb;
        longint     xf, yf, fu, fv, top, bot, res, lim, one;
        one = longint'(1) << F;
        xi  = x[F+7:F];
        yi  = y[F+7:F];
        xf  = longint'(x[F-1:0]);
        yf  = longint'(y[F-1:0]);
        fu  = fade(xf);
        fv  = fade(yf);
        a   = perm_copy[xi] + yi;
        b   = perm_copy[8'(xi + 8'd1)] + yi;
        aa  = perm_copy[a];
        ab  = perm_copy[8'(a + 8'd1)];
        ba  = perm_copy[b];
        bb  = perm_copy[8'(b + 8'd1)];
        top = lerp(grad_dot(perm_copy[aa], xf, yf), grad_dot(perm_copy[ba], xf - one, yf), fu);
        bot = lerp(grad_dot(perm_copy[ab], xf, yf - one),
                   grad_dot(perm_copy[bb], xf - one, yf - one), fu);
        res = lerp(top, bot, fv);
        lim = longint'(1) << (OUT_W - 1);
        if (res > lim - 1) res = lim - 1;
        if (res < -lim)    res = -lim;
        return res[OUT_W-1:0];
    endfunction

    // ---- driving ----
    task automatic send_beat(t_mode mode, logic [31:0] x, logic [31:0] y,
                             logic [7:0] idx, logic [7:0] val);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid       = 1'b1;
        in_bus.mode        = mode;
        in_bus.x_coord     = x;
        in_bus.y_coord     = y;
        in_bus.table_index = idx;
        in_bus.table_value = val;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (mode == MODE_LOAD)
            perm_copy[idx] = val;
        else
            noise_expected.push_back(noise_at(x, y));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (noise_expected.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk)
        out_bus.ready = ($urandom_range(99) >= recv_stall_pct);

    // ---- checking ----
    task automatic report_mismatch(string what, logic signed [OUT_W-1:0] exp_v,
                                   logic signed [OUT_W-1:0] got_v);
        $display("MISMATCH %s: expected %0d got %0d", what, exp_v, got_v);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (noise_expected.size() == 0)
                report_mismatch("unexpected beat", 'x, out_bus.noise_value);
            else if (out_bus.noise_value !== noise_expected[0]) begin
                report_mismatch("noise_value", noise_expected[0], out_bus.noise_value);
                void'(noise_expected.pop_front());
            end else
                void'(noise_expected.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---- tests ----
    // every entry written once, as a shuffled permutation, before any evaluation
    task automatic test_table_load();
        logic [7:0] shuf [TABLE_SIZE];
        logic [7:0] tmp;
        int         j;
        for (int i = 0; i < TABLE_SIZE; i++) shuf[i] = 8'(i);
        for (int i = TABLE_SIZE - 1; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = shuf[i];
            shuf[i] = shuf[j];
            shuf[j] = tmp;
        end
        for (int i = 0; i < TABLE_SIZE; i++)
            send_beat(MODE_LOAD, $urandom, $urandom, 8'(i), shuf[i]);
    endtask

    task automatic test_directed_points();
        send_beat(MODE_EVAL, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        send_beat(MODE_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 8'hFF);
        send_beat(MODE_EVAL, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 8'h00);
        send_beat(MODE_EVAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'h00); // negative, floor
        send_beat(MODE_EVAL, 32'hFFFF_8000, 32'h0000_8000, 8'h00, 8'h00);
        send_beat(MODE_EVAL, 32'h00FF_FFFF, 32'h00FF_0001, 8'h00, 8'h00); // cell wraps
        send_beat(MODE_EVAL, 32'h0001_0000, 32'hFFFF_0000, 8'h00, 8'h00);
        // load then immediately evaluate through the rewritten entries
        send_beat(MODE_LOAD, 32'h0, 32'h0, 8'h00, 8'hFF);
        send_beat(MODE_LOAD, 32'h0, 32'h0, 8'hFF, 8'h00);
        send_beat(MODE_EVAL, 32'h0000_4000, 32'h0000_C000, 8'h00, 8'h00);
        send_beat(MODE_EVAL, 32'h00FF_C000, 32'h00FF_4000, 8'h00, 8'h00);
        for (int i = 0; i < 8; i++)
            send_beat(MODE_EVAL, {8'h00, 8'(i), 16'(i * 8191)},
                      {8'hFF, 8'(i * 37), 16'hFFFF - 16'(i * 4099)}, 8'h00, 8'h00);
    endtask

    // pause until every expected result has come out
    task automatic test_drain_pause();
        wait_drained();
    endtask

    task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 15)
                send_beat(MODE_LOAD, $urandom, $urandom, 8'($urandom), 8'($urandom));
            else
                send_beat(MODE_EVAL, $urandom, $urandom, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        error_count        = 0;
        idle_count         = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.mode        = MODE_EVAL;
        in_bus.x_coord     = '0;
        in_bus.y_coord     = '0;
        in_bus.table_index = '0;
        in_bus.table_value = '0;
        out_bus.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_load();
        test_directed_points();
        test_drain_pause();
        test_random_traffic(140, 27, 83);
        test_drain_pause();
        test_random_traffic(140, 83, 27);
        test_random_traffic(140, 0, 0);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
